// ===== hdl/pwpc_pkg.sv =====
// page walk permission check: shared types, constants and index helper
// no dependencies
`default_nettype none

package pwpc_pkg;

  localparam int LEVELS     = 4;
  localparam int INDEX_BITS = 9;
  localparam int VA_W       = 48;
  localparam int PA_W       = 52;
  localparam int PAGE_OFS_W = 12;
  localparam int PAGE_W     = VA_W - PAGE_OFS_W;
  localparam int FRAME_W    = PA_W - PAGE_OFS_W;
  localparam int ENTRY_W    = 64;
  localparam int LEVEL_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(LEVELS - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_1G  = LEVEL_W'(2);
  localparam logic [LEVEL_W-1:0] LEVEL_2M  = LEVEL_W'(1);
  localparam logic [LEVEL_W-1:0] LEVEL_4K  = LEVEL_W'(0);
  localparam logic [LEVEL_W-1:0] LEVEL_ROOT4 = LEVEL_W'(3);

  localparam int PTE_PRESENT  = 0;
  localparam int PTE_WRITABLE = 1;
  localparam int PTE_LARGE    = 7;
  localparam int PTE_NO_EXEC  = 63;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_ENTRY = 1'b1;

  localparam logic KIND_READ    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [2:0] VERDICT_ALLOWED     = 3'd0;
  localparam logic [2:0] VERDICT_CONTROLS    = 3'd1;
  localparam logic [2:0] VERDICT_NOT_PRESENT = 3'd2;
  localparam logic [2:0] VERDICT_TOP_LARGE   = 3'd3;
  localparam logic [2:0] VERDICT_MISMATCH    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_PROTECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_EXECUTE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIVE_LEVEL    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME    = 2'd3;

  typedef struct packed {
    logic               action;
    logic [VA_W-1:0]    virt_address;
    logic               want_executable;
    logic [ENTRY_W-1:0] entry_value;
  } in_req_t;

  typedef struct packed {
    logic            result_kind;
    logic [PA_W-1:0] entry_address;
    logic [2:0]      verdict_code;
  } out_rsp_t;

  typedef struct packed {
    logic               write_protect_on;
    logic               no_execute_on;
    logic               five_level_on;
    logic [FRAME_W-1:0] root_frame;
  } cfg_regs_t;

  typedef struct packed {
    logic               busy;
    logic [LEVEL_W-1:0] level;
    logic [PAGE_W-1:0]  page_bits;
    logic               mode_code;
    logic               writable;
    logic               no_exec;
  } walk_state_t;

  function automatic logic [INDEX_BITS-1:0] table_index(
    input logic [PAGE_W-1:0]  page_bits,
    input logic [LEVEL_W-1:0] level
  );
    logic [PAGE_W-1:0] shifted;
    shifted = page_bits >> (int'(level) * INDEX_BITS);
    return shifted[INDEX_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pwpc_walk_step.sv =====
// page walk permission check: one walk step, next state and result
// depends on pwpc_pkg
`default_nettype none

module pwpc_walk_step (
  input  wire pwpc_pkg::in_req_t     req,
  input  wire pwpc_pkg::walk_state_t st,
  input  wire pwpc_pkg::cfg_regs_t   cfg,
  output pwpc_pkg::walk_state_t      st_nxt,
  output pwpc_pkg::out_rsp_t         rsp,
  output logic                       rsp_valid
);

  logic [pwpc_pkg::PAGE_W-1:0]     va_page;
  logic [pwpc_pkg::ENTRY_W-1:0]    pte;
  logic                            big_page;
  logic                            wr_acc;
  logic                            nx_acc;
  logic                            leaf;
  logic                            ok;
  logic [pwpc_pkg::LEVEL_W-1:0]    lvl_dn;

  assign va_page  = req.virt_address[pwpc_pkg::VA_W-1:pwpc_pkg::PAGE_OFS_W];
  assign pte      = req.entry_value;
  assign big_page = pte[pwpc_pkg::PTE_LARGE];
  assign wr_acc   = st.writable & pte[pwpc_pkg::PTE_WRITABLE];
  assign nx_acc   = st.no_exec | pte[pwpc_pkg::PTE_NO_EXEC];
  assign lvl_dn   = st.level - pwpc_pkg::LEVEL_W'(1);
  assign leaf     = (st.level == pwpc_pkg::LEVEL_4K) ||
                    (((st.level == pwpc_pkg::LEVEL_2M) || (st.level == pwpc_pkg::LEVEL_1G))
                     && big_page);
  assign ok       = st.mode_code ? (!wr_acc && !nx_acc) : (wr_acc && nx_acc);

  always_comb begin
    st_nxt    = st;
    rsp       = '0;
    rsp_valid = 1'b0;
    if (req.action == pwpc_pkg::ACT_START) begin
      st_nxt.busy = 1'b0;
      rsp_valid   = 1'b1;
      if (!cfg.write_protect_on || !cfg.no_execute_on || cfg.five_level_on) begin
        rsp.result_kind  = pwpc_pkg::KIND_VERDICT;
        rsp.verdict_code = pwpc_pkg::VERDICT_CONTROLS;
      end else begin
        st_nxt.busy      = 1'b1;
        st_nxt.level     = pwpc_pkg::TOP_LEVEL;
        st_nxt.page_bits = va_page;
        st_nxt.mode_code = req.want_executable;
        st_nxt.writable  = 1'b1;
        st_nxt.no_exec   = 1'b0;
        rsp.result_kind  = pwpc_pkg::KIND_READ;
        rsp.entry_address = {cfg.root_frame,
                             pwpc_pkg::table_index(va_page, pwpc_pkg::TOP_LEVEL), 3'b000};
      end
    end else if (st.busy) begin
      rsp_valid = 1'b1;
      if (!pte[pwpc_pkg::PTE_PRESENT]) begin
        st_nxt.busy      = 1'b0;
        rsp.result_kind  = pwpc_pkg::KIND_VERDICT;
        rsp.verdict_code = pwpc_pkg::VERDICT_NOT_PRESENT;
      end else begin
        st_nxt.writable = wr_acc;
        st_nxt.no_exec  = nx_acc;
        if (leaf) begin
          st_nxt.busy      = 1'b0;
          rsp.result_kind  = pwpc_pkg::KIND_VERDICT;
          rsp.verdict_code = ok ? pwpc_pkg::VERDICT_ALLOWED : pwpc_pkg::VERDICT_MISMATCH;
        end else if ((st.level == pwpc_pkg::LEVEL_ROOT4) && big_page) begin
          st_nxt.busy      = 1'b0;
          rsp.result_kind  = pwpc_pkg::KIND_VERDICT;
          rsp.verdict_code = pwpc_pkg::VERDICT_TOP_LARGE;
        end else begin
          st_nxt.level      = lvl_dn;
          rsp.result_kind   = pwpc_pkg::KIND_READ;
          rsp.entry_address = {pte[pwpc_pkg::PA_W-1:pwpc_pkg::PAGE_OFS_W],
                               pwpc_pkg::table_index(st.page_bits, lvl_dn), 3'b000};
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/page_walk_permission_check.sv =====
// page walk permission check top level: request register, walk state, result register
// depends on pwpc_pkg and pwpc_walk_step
// a request is registered in the input register, its result in the result register, which drives out_valid
// throughput: one request per cycle while out_ready is high; the walk state updates in the single step stage
// a request is held in the input register only while a result waits and out_ready is low
// reset (rst_n low, synchronous): no walk in progress, all control registers cleared
`default_nettype none

module page_walk_permission_check (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_wr_en,
  input  wire [pwpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [pwpc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire pwpc_pkg::in_req_t              in_req,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output pwpc_pkg::out_rsp_t                  out_rsp
);

  pwpc_pkg::cfg_regs_t   cfg_r;
  pwpc_pkg::walk_state_t st_r;
  pwpc_pkg::walk_state_t st_nxt;
  pwpc_pkg::in_req_t     in_req_r;
  pwpc_pkg::out_rsp_t    out_rsp_r;
  pwpc_pkg::out_rsp_t    rsp;
  logic                  in_valid_r;
  logic                  out_valid_r;
  logic                  rsp_valid;
  logic                  step_fire;

  pwpc_walk_step u_step (
    .req       (in_req_r),
    .st        (st_r),
    .cfg       (cfg_r),
    .st_nxt    (st_nxt),
    .rsp       (rsp),
    .rsp_valid (rsp_valid)
  );

  assign step_fire = in_valid_r && (!rsp_valid || !out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || step_fire;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      st_r        <= '{busy: 1'b0, level: '0, page_bits: '0, mode_code: 1'b0,
                       writable: 1'b1, no_exec: 1'b0};
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          pwpc_pkg::CFG_WRITE_PROTECT: cfg_r.write_protect_on <= cfg_wdata[0];
          pwpc_pkg::CFG_NO_EXECUTE:    cfg_r.no_execute_on    <= cfg_wdata[0];
          pwpc_pkg::CFG_FIVE_LEVEL:    cfg_r.five_level_on    <= cfg_wdata[0];
          pwpc_pkg::CFG_ROOT_FRAME:    cfg_r.root_frame       <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (step_fire) begin
        st_r <= st_nxt;
      end
      if (step_fire && rsp_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_req_r <= in_req;
    end
    if (step_fire && rsp_valid) begin
      out_rsp_r <= rsp;
    end
  end

  a_verdict_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_rsp_r.result_kind == pwpc_pkg::KIND_VERDICT)
    |-> (out_rsp_r.entry_address == '0))
    else $error("verdict carries a nonzero entry address");

  a_read_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_rsp_r.result_kind == pwpc_pkg::KIND_READ)
    |-> (out_rsp_r.verdict_code == pwpc_pkg::VERDICT_ALLOWED))
    else $error("read request carries a verdict code");

  a_verdict_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire && rsp_valid && (rsp.result_kind == pwpc_pkg::KIND_VERDICT)
    |=> !st_r.busy)
    else $error("walk still busy after a verdict");

  a_read_keeps_walk: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire && rsp_valid && (rsp.result_kind == pwpc_pkg::KIND_READ)
    |=> st_r.busy)
    else $error("walk idle after an entry read request");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.busy |-> (st_r.level <= pwpc_pkg::TOP_LEVEL))
    else $error("walk level above the top level");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking bench for page_walk_permission_check: directed and random page walks
// predicts every entry read and verdict in its own walk model and checks them in order
// depends on pwpc_pkg and the page_walk_permission_check rtl
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pwpc_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 256;
  localparam logic [FRAME_W-1:0] ROOT_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_req_t               in_req = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_rsp_t              out_rsp;

  page_walk_permission_check u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register copies and walk state of the predictor
  logic               reg_write_protect = 1'b0;
  logic               reg_no_execute = 1'b0;
  logic               reg_five_level = 1'b0;
  logic [FRAME_W-1:0] reg_root_frame = '0;

  logic               walk_busy = 1'b0;
  logic [LEVEL_W-1:0] walk_level = '0;
  logic [PAGE_W-1:0]  walk_page = '0;
  logic               walk_code = 1'b0;
  logic               walk_writable = 1'b1;
  logic               walk_no_exec = 1'b0;

  in_req_t  pending_reqs[$];
  out_rsp_t expected_rsps[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int long_holds_ordered = 0;
  int long_holds_done = 0;
  int hold_left = 0;
  int stim_count = 0;
  int starts_sent = 0;
  int entries_sent = 0;
  int results_checked = 0;
  int reads_seen = 0;
  int verdict_seen[8];
  int mismatch_count = 0;
  int quiet_cycles = 0;

  function automatic logic [PA_W-1:0] entry_slot(input logic [PA_W-1:0] base,
                                                 input logic [PAGE_W-1:0] page,
                                                 input logic [LEVEL_W-1:0] lvl);
    logic [INDEX_BITS-1:0] idx;
    idx = page[int'(lvl)*INDEX_BITS +: INDEX_BITS];
    entry_slot = {base[PA_W-1:PAGE_OFS_W], {PAGE_OFS_W{1'b0}}} + (PA_W'(idx) << 3);
  endfunction

  task automatic finish_walk(input logic [2:0] code);
    out_rsp_t rsp;
    rsp = '0;
    rsp.result_kind = KIND_VERDICT;
    rsp.verdict_code = code;
    walk_busy = 1'b0;
    expected_rsps.push_back(rsp);
  endtask

  task automatic request_entry(input logic [PA_W-1:0] base);
    out_rsp_t rsp;
    rsp = '0;
    rsp.result_kind = KIND_READ;
    rsp.entry_address = entry_slot(base, walk_page, walk_level);
    expected_rsps.push_back(rsp);
  endtask

  task automatic walk_predict(input in_req_t req);
    logic [ENTRY_W-1:0] pte;
    logic big_page;
    logic ok;
    if (req.action == ACT_START) begin
      walk_busy = 1'b0;
      if (!reg_write_protect || !reg_no_execute || reg_five_level) begin
        finish_walk(VERDICT_CONTROLS);
      end else begin
        walk_page = req.virt_address[VA_W-1:PAGE_OFS_W];
        walk_code = req.want_executable;
        walk_writable = 1'b1;
        walk_no_exec = 1'b0;
        walk_level = TOP_LEVEL;
        walk_busy = 1'b1;
        request_entry({reg_root_frame, {PAGE_OFS_W{1'b0}}});
      end
    end else if (walk_busy) begin
      pte = req.entry_value;
      big_page = pte[PTE_LARGE];
      if (!pte[PTE_PRESENT]) begin
        finish_walk(VERDICT_NOT_PRESENT);
      end else begin
        walk_writable = walk_writable & pte[PTE_WRITABLE];
        walk_no_exec = walk_no_exec | pte[PTE_NO_EXEC];
        if (walk_level == LEVEL_4K ||
            ((walk_level == LEVEL_2M || walk_level == LEVEL_1G) && big_page)) begin
          ok = walk_code ? (!walk_writable && !walk_no_exec) : (walk_writable && walk_no_exec);
          finish_walk(ok ? VERDICT_ALLOWED : VERDICT_MISMATCH);
        end else if (walk_level == LEVEL_ROOT4 && big_page) begin
          finish_walk(VERDICT_TOP_LARGE);
        end else begin
          walk_level = walk_level - 1'b1;
          request_entry(pte[PA_W-1:0]);
        end
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        walk_predict(in_req);
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_req <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    mismatch_count++;
  endtask

  task automatic check_result(input out_rsp_t got);
    out_rsp_t want;
    if (expected_rsps.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0d addr %0h code %0d",
               $time, got.result_kind, got.entry_address, got.verdict_code);
      mismatch_count++;
    end else begin
      want = expected_rsps.pop_front();
      results_checked++;
      if (got.result_kind !== want.result_kind)
        report("result_kind", 64'(want.result_kind), 64'(got.result_kind));
      if (got.entry_address !== want.entry_address)
        report("entry_address", 64'(want.entry_address), 64'(got.entry_address));
      if (got.verdict_code !== want.verdict_code)
        report("verdict_code", 64'(want.verdict_code), 64'(got.verdict_code));
      if (want.result_kind == KIND_READ)
        reads_seen++;
      else
        verdict_seen[want.verdict_code]++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_rsp);
      end
      if (long_holds_done != long_holds_ordered) begin
        long_holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_rsps.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [CFG_DATA_W-1:0] flag_word(input logic b);
    flag_word = {$urandom(), 8'($urandom())};
    flag_word[0] = b;
  endfunction

  task automatic program_walker(input logic wp, input logic nx, input logic fl,
                                input logic [FRAME_W-1:0] root);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WRITE_PROTECT;
    cfg_wdata <= flag_word(wp);
    @(posedge clk);
    cfg_index <= CFG_NO_EXECUTE;
    cfg_wdata <= flag_word(nx);
    @(posedge clk);
    cfg_index <= CFG_FIVE_LEVEL;
    cfg_wdata <= flag_word(fl);
    @(posedge clk);
    cfg_index <= CFG_ROOT_FRAME;
    cfg_wdata <= root;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reg_write_protect = wp;
    reg_no_execute = nx;
    reg_five_level = fl;
    reg_root_frame = root;
  endtask

  task automatic settle();
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_start(input logic [VA_W-1:0] va, input logic code);
    in_req_t req;
    req.action = ACT_START;
    req.virt_address = va;
    req.want_executable = code;
    req.entry_value = {$urandom(), $urandom()};
    pending_reqs.push_back(req);
    stim_count++;
    starts_sent++;
  endtask

  task automatic queue_entry(input logic [ENTRY_W-1:0] pte);
    in_req_t req;
    req.action = ACT_ENTRY;
    req.virt_address = {16'($urandom()), $urandom()};
    req.want_executable = 1'($urandom());
    req.entry_value = pte;
    pending_reqs.push_back(req);
    stim_count++;
    entries_sent++;
  endtask

  // mostly complete walks, some cut short, a few stray entries
  task automatic queue_random_walk();
    logic code;
    logic aim_ok;
    logic done;
    logic [ENTRY_W-1:0] pte;
    int lvl;
    int cut_at;
    int n;
    code = 1'($urandom());
    aim_ok = 1'($urandom());
    cut_at = ($urandom_range(9) == 0) ? $urandom_range(3) : -1;
    queue_start({16'($urandom()), $urandom()}, code);
    lvl = int'(TOP_LEVEL);
    n = 0;
    done = 1'b0;
    while (!done && n != cut_at) begin
      pte = {$urandom(), $urandom()};
      pte[PTE_PRESENT] = ($urandom_range(19) != 0);
      if (lvl == 3)
        pte[PTE_LARGE] = ($urandom_range(19) == 0);
      else if (lvl != 0)
        pte[PTE_LARGE] = ($urandom_range(3) == 0);
      if (aim_ok && code)
        pte[PTE_NO_EXEC] = 1'b0;
      else if (aim_ok)
        pte[PTE_WRITABLE] = 1'b1;
      queue_entry(pte);
      n++;
      done = !pte[PTE_PRESENT] || lvl == 0 || pte[PTE_LARGE];
      lvl--;
    end
    if ($urandom_range(12) == 0)
      queue_entry({$urandom(), $urandom()});
  endtask

  task automatic random_phase(input int items);
    int target;
    target = stim_count + items;
    while (stim_count < target)
      queue_random_walk();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // control registers unsuitable: verdict at once, entries ignored
    program_walker(1'b0, 1'b0, 1'b0, '0);
    queue_start(48'hFFFF_FFFF_FFFF, 1'b1);
    queue_entry('1);
    settle();
    program_walker(1'b0, 1'b1, 1'b0, ROOT_MAX);
    queue_start(48'h0, 1'b0);
    settle();
    program_walker(1'b1, 1'b0, 1'b0, '0);
    queue_start(48'hFFFF_FFFF_FFFF, 1'b0);
    settle();
    program_walker(1'b1, 1'b1, 1'b1, ROOT_MAX);
    queue_start(48'h8000_0000_0000, 1'b1);
    settle();

    program_walker(1'b1, 1'b1, 1'b0, ROOT_MAX);
    // absent top entry, large bit at top
    queue_start(48'hFFFF_FFFF_FFFF, 1'b1);
    queue_entry('0);
    queue_start(48'h0, 1'b0);
    queue_entry('1);
    // full 4k walk to a code page
    queue_start(48'hFFFF_FFFF_FFFF, 1'b1);
    repeat (4) queue_entry(64'h000F_FFFF_FFFF_F001);
    // 2m data page
    queue_start(48'h5555_5555_5000, 1'b0);
    queue_entry(64'h0000_0123_4567_8003);
    queue_entry(64'h8000_0abc_def0_1003);
    queue_entry(64'h0000_0000_0000_0083);
    // 2m code page left writable
    queue_start(48'h0000_8040_2010, 1'b1);
    queue_entry(64'h0000_0123_4567_8003);
    queue_entry(64'h000A_AAAA_AAAA_A003);
    queue_entry(64'h0000_0000_0000_0083);
    // new walk while one is in progress
    queue_start(48'hAAAA_AAAA_AFFF, 1'b0);
    queue_entry(64'h0000_0000_0000_1003);
    queue_start(48'h1234_5678_9ABC, 1'b1);
    queue_entry('1);
    settle();

    program_walker(1'b1, 1'b1, 1'b0, '0);
    send_idle_pct = 0;
    stall_pct = 0;
    random_phase(PHASE_ITEMS);
    long_holds_ordered++;
    settle();

    program_walker(1'b1, 1'b1, 1'b0, ROOT_MAX);
    send_idle_pct = 45;
    stall_pct = 0;
    random_phase(PHASE_ITEMS / 2);
    settle();
    random_phase(PHASE_ITEMS / 2);
    settle();

    program_walker(1'b1, 1'b1, 1'b0, {$urandom(), 8'($urandom())});
    send_idle_pct = 0;
    stall_pct = 45;
    random_phase(PHASE_ITEMS);
    settle();

    program_walker(1'b1, 1'b1, 1'b0, {$urandom(), 8'($urandom())});
    send_idle_pct = 30;
    stall_pct = 30;
    random_phase(PHASE_ITEMS);
    settle();

    $display("covered %0d requests (%0d walk starts, %0d table entries) over 9 register settings",
             stim_count, starts_sent, entries_sent);
    $display("checked %0d results: %0d entry reads", results_checked, reads_seen);
    $display("verdicts ok/ctrl/absent/top/perm %0d/%0d/%0d/%0d/%0d",
             verdict_seen[VERDICT_ALLOWED], verdict_seen[VERDICT_CONTROLS],
             verdict_seen[VERDICT_NOT_PRESENT], verdict_seen[VERDICT_TOP_LARGE],
             verdict_seen[VERDICT_MISMATCH]);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/pwpc_pkg.sv
hdl/pwpc_walk_step.sv
hdl/page_walk_permission_check.sv
tb/sv/testbench.sv
